// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the scatter-gather block iterator.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, suspended while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising clock edge, suspended while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- sv/dsbi_pkg.sv -----
// Package for the scatter-gather block iterator: item codes, sequencer states,
// register map and default sizes. Depends on nothing.
`default_nettype none

package dsbi_pkg;

	localparam int SEG_DEPTH_DEF = 64;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_PAGE_SHIFT = 1'b0;
	localparam logic [5:0] PAGE_SHIFT_RST = 6'd12;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_START = 2'd1,
		MODE_NEXT  = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_DELTA,
		ST_CHECK,
		ST_WAIT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- sv/dma_sg_block_iterator.sv -----
// Top level of the scatter-gather block iterator: segment table, walk sequencer
// and APB register. Depends on dsbi_pkg and assert_macros.svh.
//
//  Channel   Handshake                    Payload
//  item      item_valid / item_stall      mode, entry_index, segment_address,
//                                         segment_length, segment_count
//  result    result_valid / result_stall  block_address, block_valid
//  config    APB psel/penable/pwrite      paddr, pwdata, prdata (page_shift at 0)
//
// Load, start and idle transactions, and a next one with no segment left, leave
// their result in the output register at once. Other next transactions pass
// ST_ADDR, ST_DELTA and ST_CHECK, with one shared compare-and-subtract step per
// segment consumed and a ST_WAIT state to read the next table entry. Reset
// clears the walk state and sets page_shift to 12; the table is not cleared.
// A stalled result holds the output register and stops new transactions.
`default_nettype none

`include "assert_macros.svh"

module dma_sg_block_iterator #(
	parameter int SEG_DEPTH = dsbi_pkg::SEG_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic [1:0]                   mode,
	input  wire logic [5:0]                   entry_index,
	input  wire logic [63:0]                  segment_address,
	input  wire logic [31:0]                  segment_length,
	input  wire logic [6:0]                   segment_count,

	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic [63:0]                       block_address,
	output logic                              block_valid,

	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dsbi_pkg::PADDR_W-1:0] paddr,
	input  wire logic [dsbi_pkg::PDATA_W-1:0] pwdata,
	output logic [dsbi_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);

	localparam int IW = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
	localparam int CW = $clog2(SEG_DEPTH + 1);

	dsbi_pkg::state_t state_q, state_d;

	logic [5:0]    page_shift_q;
	logic [CW-1:0] cursor_q, cursor_d;
	logic [6:0]    left_q, left_d;
	logic [31:0]   off_q, off_d;
	logic [63:0]   addr_q, addr_d;
	logic [63:0]   delta_q, delta_d;

	logic          result_valid_q, result_valid_d;
	logic [63:0]   block_address_q, block_address_d;
	logic          block_valid_q, block_valid_d;

	logic [95:0]   mem [SEG_DEPTH];
	logic [95:0]   rd_q;
	logic          mem_we;
	logic [IW-1:0] mem_wa;

	logic          out_free;
	logic          accept;
	logic          have_seg;
	logic [31:0]   rest;
	logic          consume;
	logic [63:0]   mask;
	logic [31:0]   idx_ext;
	logic [31:0]   cnt_ext;
	logic          cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign prdata   = (paddr[2] == dsbi_pkg::REG_PAGE_SHIFT) ?
	                  dsbi_pkg::PDATA_W'(page_shift_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= dsbi_pkg::PAGE_SHIFT_RST;
		end else if (cfg_wr && paddr[2] == dsbi_pkg::REG_PAGE_SHIFT) begin
			page_shift_q <= pwdata[5:0];
		end
	end

	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = (state_q != dsbi_pkg::ST_IDLE) || !out_free;
	assign accept     = item_valid && !item_stall;

	assign idx_ext  = 32'(entry_index);
	assign cnt_ext  = 32'(segment_count);
	assign mem_wa   = idx_ext[IW-1:0];
	assign mem_we   = accept && (dsbi_pkg::mode_t'(mode) == dsbi_pkg::MODE_LOAD) &&
	                  (idx_ext < 32'(SEG_DEPTH));

	assign have_seg = (left_q != 7'd0) && (32'(cursor_q) < 32'(SEG_DEPTH));
	assign rest     = rd_q[31:0] - off_q;
	assign consume  = {32'd0, rest} <= delta_q;
	assign mask     = (64'd1 << page_shift_q) - 64'd1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= {segment_address, segment_length};
		end
		rd_q <= mem[cursor_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsbi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		cursor_d        = cursor_q;
		left_d          = left_q;
		off_d           = off_q;
		addr_d          = addr_q;
		delta_d         = delta_q;
		result_valid_d  = result_valid_q && result_stall;
		block_address_d = block_address_q;
		block_valid_d   = block_valid_q;
		case (state_q)
			dsbi_pkg::ST_IDLE: begin
				if (accept) begin
					case (dsbi_pkg::mode_t'(mode))
						dsbi_pkg::MODE_START: begin
							cursor_d        = '0;
							off_d           = '0;
							left_d          = (cnt_ext > 32'(SEG_DEPTH)) ?
							                  7'(SEG_DEPTH) : segment_count;
							result_valid_d  = 1'b1;
							block_address_d = '0;
							block_valid_d   = 1'b0;
						end
						dsbi_pkg::MODE_NEXT: begin
							if (have_seg) begin
								state_d = dsbi_pkg::ST_ADDR;
							end else begin
								result_valid_d  = 1'b1;
								block_address_d = '0;
								block_valid_d   = 1'b0;
							end
						end
						default: begin
							result_valid_d  = 1'b1;
							block_address_d = '0;
							block_valid_d   = 1'b0;
						end
					endcase
				end
			end
			dsbi_pkg::ST_ADDR: begin
				addr_d  = rd_q[95:32] + 64'(off_q);
				state_d = dsbi_pkg::ST_DELTA;
			end
			dsbi_pkg::ST_DELTA: begin
				delta_d = (~addr_q & mask) + 64'd1;
				state_d = dsbi_pkg::ST_CHECK;
			end
			dsbi_pkg::ST_CHECK: begin
				if (have_seg && consume) begin
					delta_d  = delta_q - 64'(rest);
					off_d    = '0;
					cursor_d = cursor_q + CW'(1);
					left_d   = left_q - 7'd1;
					state_d  = dsbi_pkg::ST_WAIT;
				end else begin
					off_d   = off_q + delta_q[31:0];
					state_d = dsbi_pkg::ST_DONE;
				end
			end
			dsbi_pkg::ST_WAIT: begin
				state_d = dsbi_pkg::ST_CHECK;
			end
			dsbi_pkg::ST_DONE: begin
				if (out_free) begin
					result_valid_d  = 1'b1;
					block_address_d = addr_q;
					block_valid_d   = 1'b1;
					state_d         = dsbi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dsbi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q       <= '0;
			left_q         <= '0;
			off_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			cursor_q       <= cursor_d;
			left_q         <= left_d;
			off_q          <= off_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q          <= addr_d;
		delta_q         <= delta_d;
		block_address_q <= block_address_d;
		block_valid_q   <= block_valid_d;
	end

	assign result_valid  = result_valid_q;
	assign block_address = block_address_q;
	assign block_valid   = block_valid_q;

	// The cursor and the segments still to walk never reach beyond the table.
	`ASSERT_CLK(a_walk_in_table, clk, arst_n, (32'(cursor_q) + 32'(left_q) <= 32'(SEG_DEPTH)), "walk runs past the segment table")
	// A result without a block always carries a zero address.
	`ASSERT_IMPL(a_invalid_zero, clk, arst_n, result_valid_q && !block_valid_q, block_address_q == 64'd0, "invalid result with non-zero address")
	// Segments are only consumed during a walk, one at a time.
	`ASSERT_IMPL(a_consume_step, clk, arst_n, state_q != dsbi_pkg::ST_IDLE && left_q != $past(left_q), left_q == $past(left_q) - 7'd1 && state_q == dsbi_pkg::ST_WAIT, "segment count changed outside a consume step")

endmodule

`default_nettype wire
